[sv/dsrp_pkg.sv]
// shared types, constants and register codes for the dsd stereo repacker
package dsrp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CNTB_W  = 3;
	localparam int unsigned PAD_W   = 3;
	localparam int unsigned BLK_W   = 6;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [BYTE_W-1:0] DSD_SILENCE = 8'h69;

	typedef enum logic {
		REG_PAD   = 1'b0,
		REG_BLOCK = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RIGHT,
		ST_FILL_L,
		ST_FILL_R,
		ST_ENDED
	} state_t;

	typedef struct packed {
		logic take_item;
		logic emit_right;
		logic emit_fill;
		logic fill_chan;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic eos;
		logic need_fill;
		logic fill_last;
	} dp_stat_t;

endpackage

[sv/dsrp_chunk_if.sv]
// input channel: one stereo dsd chunk per beat
interface dsrp_chunk_if;
	logic                          valid;
	logic                          ready;
	logic [dsrp_pkg::BYTE_W-1:0]   left_first;
	logic [dsrp_pkg::BYTE_W-1:0]   right_first;
	logic [dsrp_pkg::BYTE_W-1:0]   left_second;
	logic [dsrp_pkg::BYTE_W-1:0]   right_second;
	logic                          end_of_stream;

	modport source (
		output valid, left_first, right_first, left_second, right_second, end_of_stream,
		input  ready
	);
	modport sink (
		input  valid, left_first, right_first, left_second, right_second, end_of_stream,
		output ready
	);
endinterface

[sv/dsrp_word_if.sv]
// output channel: one channel word per beat
interface dsrp_word_if;
	logic                          valid;
	logic                          ready;
	logic [dsrp_pkg::WORD_W-1:0]   data_word;
	logic [dsrp_pkg::CNTB_W-1:0]   byte_count;
	logic                          channel;
	logic                          is_silence;
	logic                          last;

	modport source (
		output valid, data_word, byte_count, channel, is_silence, last,
		input  ready
	);
	modport sink (
		input  valid, data_word, byte_count, channel, is_silence, last,
		output ready
	);
endinterface

[sv/dsrp_regs.sv]
// apb configuration registers: padding bytes and sample block size
module dsrp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsrp_pkg::APB_AW-1:0]   paddr,
	input  logic [dsrp_pkg::APB_DW-1:0]   pwdata,
	output logic [dsrp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [dsrp_pkg::PAD_W-1:0]    pad_bytes,
	output logic [dsrp_pkg::BLK_W-1:0]    block_words
);

	logic [dsrp_pkg::PAD_W-1:0] pad_q;
	logic [dsrp_pkg::BLK_W-1:0] blk_q;
	logic                       wr_en;
	dsrp_pkg::reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = dsrp_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= 3'd0;
			blk_q <= 6'd4;
		end else if (wr_en) begin
			case (idx)
				dsrp_pkg::REG_PAD:   pad_q <= pwdata[dsrp_pkg::PAD_W-1:0];
				dsrp_pkg::REG_BLOCK: blk_q <= pwdata[dsrp_pkg::BLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dsrp_pkg::REG_PAD:   prdata = {{(dsrp_pkg::APB_DW-dsrp_pkg::PAD_W){1'b0}}, pad_q};
			dsrp_pkg::REG_BLOCK: prdata = {{(dsrp_pkg::APB_DW-dsrp_pkg::BLK_W){1'b0}}, blk_q};
			default:             prdata = '0;
		endcase
	end

	assign pad_bytes   = pad_q;
	assign block_words = blk_q;

endmodule

[sv/dsrp_ctrl.sv]
// sequencer: left word on take, then right word, then silence fill chunks
module dsrp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsrp_pkg::dp_stat_t  stat,
	output dsrp_pkg::ctl_cmd_t  cmd
);

	dsrp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			dsrp_pkg::ST_IDLE: begin
				in_ready = stat.slot_free;
				if (in_valid && stat.slot_free) begin
					cmd.take_item = 1'b1;
					state_d       = dsrp_pkg::ST_RIGHT;
				end
			end
			dsrp_pkg::ST_RIGHT: begin
				if (stat.slot_free) begin
					cmd.emit_right = 1'b1;
					if (stat.need_fill) begin
						state_d = dsrp_pkg::ST_FILL_L;
					end else if (stat.eos) begin
						state_d = dsrp_pkg::ST_ENDED;
					end else begin
						state_d = dsrp_pkg::ST_IDLE;
					end
				end
			end
			dsrp_pkg::ST_FILL_L: begin
				if (stat.slot_free) begin
					cmd.emit_fill = 1'b1;
					state_d       = dsrp_pkg::ST_FILL_R;
				end
			end
			dsrp_pkg::ST_FILL_R: begin
				if (stat.slot_free) begin
					cmd.emit_fill = 1'b1;
					cmd.fill_chan = 1'b1;
					state_d       = stat.fill_last ? dsrp_pkg::ST_ENDED : dsrp_pkg::ST_FILL_L;
				end
			end
			dsrp_pkg::ST_ENDED: begin
				// chunks after the end of the stream are taken and dropped
				in_ready = 1'b1;
			end
			default: begin
				state_d = dsrp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/dsrp_datapath.sv]
// chunk latch, block counters, word assembly and output register
module dsrp_datapath #(
	parameter int unsigned MAX_BLOCK_CHUNKS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [dsrp_pkg::PAD_W-1:0]        pad_bytes,
	input  logic [dsrp_pkg::BLK_W-1:0]        block_words,
	dsrp_chunk_if.sink                        chunk,
	dsrp_word_if.source                       word,
	input  dsrp_pkg::ctl_cmd_t                cmd,
	output dsrp_pkg::dp_stat_t                stat
);

	localparam int unsigned CNT_W = $clog2(MAX_BLOCK_CHUNKS + 1);
	localparam logic [CNT_W-1:0] CPB_MAX = CNT_W'(MAX_BLOCK_CHUNKS);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	logic [dsrp_pkg::BYTE_W-1:0] r0_q, r1_q;
	logic                        eos_q;
	logic [CNT_W-1:0]            cnt_q, fill_q;

	logic                        out_valid_q;
	logic [dsrp_pkg::WORD_W-1:0] out_data_q;
	logic [dsrp_pkg::CNTB_W-1:0] out_cnt_q;
	logic                        out_chan_q, out_sil_q, out_last_q;

	logic [1:0]                  half_pad;
	logic [dsrp_pkg::CNTB_W-1:0] byte_cnt;
	logic [6:0]                  dbl_words;
	logic [14:0]                 div3_prod;
	logic [dsrp_pkg::BLK_W-1:0]  fit;
	logic [CNT_W-1:0]            cpb;
	logic [CNT_W-1:0]            placed;
	logic                        need_fill;
	logic [dsrp_pkg::WORD_W-1:0] sil_word;
	logic                        slot_free;
	logic                        emit;

	// odd padding rounds down, above four saturates
	assign half_pad = (pad_bytes[2:1] > 2'd2) ? 2'd2 : pad_bytes[2:1];
	assign byte_cnt = 3'd2 + {1'b0, half_pad};

	// chunks per block: words*4 / (4 + 2*half_pad); the six-byte case is 2*words/3
	assign dbl_words = {block_words, 1'b0};
	assign div3_prod = 15'(dbl_words) * 15'd171;

	always_comb begin
		case (half_pad)
			2'd0:    fit = block_words;
			2'd1:    fit = div3_prod[14:9];
			default: fit = {1'b0, block_words[dsrp_pkg::BLK_W-1:1]};
		endcase
		if (fit == '0) begin
			cpb = ONE;
		end else if (32'(fit) > MAX_BLOCK_CHUNKS) begin
			cpb = CPB_MAX;
		end else begin
			cpb = CNT_W'(fit);
		end
	end

	// a count that already reaches the block size closes the block
	assign placed    = ((cnt_q + ONE) >= cpb) ? '0 : cnt_q + ONE;
	assign need_fill = eos_q && (placed != '0);

	always_comb begin
		case (byte_cnt)
			3'd2:    sil_word = {16'h0, dsrp_pkg::DSD_SILENCE, dsrp_pkg::DSD_SILENCE};
			3'd3:    sil_word = {8'h0, dsrp_pkg::DSD_SILENCE, dsrp_pkg::DSD_SILENCE,
				dsrp_pkg::DSD_SILENCE};
			default: sil_word = {dsrp_pkg::DSD_SILENCE, dsrp_pkg::DSD_SILENCE,
				dsrp_pkg::DSD_SILENCE, dsrp_pkg::DSD_SILENCE};
		endcase
	end

	assign slot_free = !out_valid_q || word.ready;
	assign emit      = cmd.take_item || cmd.emit_right || cmd.emit_fill;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			r0_q  <= chunk.right_first;
			r1_q  <= chunk.right_second;
			eos_q <= chunk.end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= '0;
		end else if (cmd.emit_right) begin
			cnt_q  <= eos_q ? '0 : placed;
			fill_q <= cpb - placed;
		end else if (cmd.emit_fill && cmd.fill_chan) begin
			fill_q <= fill_q - ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (word.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			out_data_q <= {16'h0, chunk.left_first, chunk.left_second};
			out_cnt_q  <= byte_cnt;
			out_chan_q <= 1'b0;
			out_sil_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (cmd.emit_right) begin
			out_data_q <= {16'h0, r0_q, r1_q};
			out_cnt_q  <= byte_cnt;
			out_chan_q <= 1'b1;
			out_sil_q  <= 1'b0;
			out_last_q <= !need_fill;
		end else if (cmd.emit_fill) begin
			out_data_q <= sil_word;
			out_cnt_q  <= byte_cnt;
			out_chan_q <= cmd.fill_chan;
			out_sil_q  <= 1'b1;
			out_last_q <= cmd.fill_chan && (fill_q == ONE);
		end
	end

	assign word.valid      = out_valid_q;
	assign word.data_word  = out_data_q;
	assign word.byte_count = out_cnt_q;
	assign word.channel    = out_chan_q;
	assign word.is_silence = out_sil_q;
	assign word.last       = out_last_q;

	assign stat.slot_free = slot_free;
	assign stat.eos       = eos_q;
	assign stat.need_fill = need_fill;
	assign stat.fill_last = (fill_q == ONE);

endmodule

[sv/dsd_stereo_repack_pad.sv]
// top level of the dsd stereo repacker with padding and silence fill
//
//  port    dir   beat content
//  chunk   in    L0, R0, L1, R1, end_of_stream
//  word    out   data_word, byte_count, channel, is_silence, last
//  apb     cfg   pad_bytes_per_chunk @ 0x0, sample_block_words @ 0x4
//
// a chunk's left word loads into the output register on the accepting edge and its right
// word once that register is free; each silence fill chunk adds a left and a right word.
// the single output register sets the rate: one word per cycle unless word stalls.
// reset clears the state machine, block count and output valid; registers go to 0 and 4.
// a stall on word holds the output register and the sequencer in place.
module dsd_stereo_repack_pad #(
	parameter int unsigned MAX_BLOCK_CHUNKS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dsrp_chunk_if.sink                    chunk,
	dsrp_word_if.source                   word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsrp_pkg::APB_AW-1:0]   paddr,
	input  logic [dsrp_pkg::APB_DW-1:0]   pwdata,
	output logic [dsrp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [dsrp_pkg::PAD_W-1:0] pad_bytes;
	logic [dsrp_pkg::BLK_W-1:0] block_words;
	dsrp_pkg::ctl_cmd_t         cmd;
	dsrp_pkg::dp_stat_t         stat;
	logic                       in_ready;

	assign chunk.ready = in_ready;

	dsrp_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.pad_bytes   (pad_bytes),
		.block_words (block_words)
	);

	dsrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chunk.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsrp_datapath #(
		.MAX_BLOCK_CHUNKS (MAX_BLOCK_CHUNKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.pad_bytes   (pad_bytes),
		.block_words (block_words),
		.chunk       (chunk),
		.word        (word),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

[sv/dsrp_checker.sv]
// port-level checks on the repacker output, bound to the top level
module dsrp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [dsrp_pkg::WORD_W-1:0]   data_word,
	input logic                          channel,
	input logic                          is_silence,
	input logic                          last
);

	// a stalled word holds its data
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_word))
		else $error("output word changed under stall");

	// fill words carry silence bytes in the low half
	a_silence_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_silence |->
			data_word[7:0] == dsrp_pkg::DSD_SILENCE &&
			data_word[15:8] == dsrp_pkg::DSD_SILENCE)
		else $error("silence word without 0x69 bytes");

	// audio words keep the padding bytes zero
	a_audio_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_silence |-> data_word[31:16] == 16'h0)
		else $error("audio word with nonzero padding");

	// a chunk always ends on its right word
	a_left_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !channel |-> !last)
		else $error("left word marked last");

endmodule

bind dsd_stereo_repack_pad dsrp_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (word.valid),
	.out_ready  (word.ready),
	.data_word  (word.data_word),
	.channel    (word.channel),
	.is_silence (word.is_silence),
	.last       (word.last)
);

[dv/tb_top.sv]
// self-checking testbench for the dsd stereo repacker with padding and silence fill
module tb_top;

	localparam int unsigned MAX_CHUNKS = 32;

	typedef struct {
		logic [dsrp_pkg::BYTE_W-1:0] l0;
		logic [dsrp_pkg::BYTE_W-1:0] r0;
		logic [dsrp_pkg::BYTE_W-1:0] l1;
		logic [dsrp_pkg::BYTE_W-1:0] r1;
		logic                        eos;
	} chunk_t;

	typedef struct {
		logic [dsrp_pkg::WORD_W-1:0] data;
		logic [dsrp_pkg::CNTB_W-1:0] nbytes;
		logic                        chan;
		logic                        silence;
		logic                        last;
	} word_t;

	typedef enum bit {ROW_CHUNK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		chunk_t              c;
		bit                  typed;
		logic [31:0]         exp_l;
		logic [31:0]         exp_r;
		dsrp_pkg::reg_idx_t  idx;
		logic [31:0]         val;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dsrp_pkg::APB_AW-1:0] paddr;
	logic [dsrp_pkg::APB_DW-1:0] pwdata;
	logic [dsrp_pkg::APB_DW-1:0] prdata;
	logic pready;

	dsrp_chunk_if chunk_bus ();
	dsrp_word_if  word_bus ();

	dsd_stereo_repack_pad #(.MAX_BLOCK_CHUNKS(MAX_CHUNKS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chunk   (chunk_bus),
		.word    (word_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state and register copies
	logic [dsrp_pkg::PAD_W-1:0] pad_reg;
	logic [dsrp_pkg::BLK_W-1:0] blk_reg;
	logic [4:0]                 blk_chunks;
	bit                         stream_done;

	word_t pending_words[$];
	int    errors;
	bit    src_idle;
	bit    sink_idle;
	row_t  plan[$];

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	task automatic report(input string what, input logic [31:0] expv, input logic [31:0] got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, expv, got, $realtime);
		errors++;
	endtask

	// words caused by one chunk, updating the block count
	function automatic void repack_chunk(input chunk_t c, output word_t res[$]);
		logic [2:0]  half;
		logic [2:0]  nbytes;
		int unsigned cpb;
		int unsigned placed;
		logic [31:0] fill_word;
		word_t       w;
		res = {};
		if (stream_done)
			return;
		half = pad_reg >> 1;
		if (half > 3'd2)
			half = 3'd2;
		nbytes = 3'd2 + half;
		cpb = (32'(blk_reg) * 4) / (4 + 2 * 32'(half));
		if (cpb < 1)
			cpb = 1;
		if (cpb > MAX_CHUNKS)
			cpb = MAX_CHUNKS;
		w.nbytes = nbytes;
		w.last = 1'b0;
		w.silence = 1'b0;
		w.data = {16'h0, c.l0, c.l1};
		w.chan = 1'b0;
		res.push_back(w);
		w.data = {16'h0, c.r0, c.r1};
		w.chan = 1'b1;
		res.push_back(w);
		placed = 32'(blk_chunks) + 1;
		if (placed >= cpb)
			placed = 0;
		if (c.eos) begin
			if (placed != 0) begin
				fill_word = '0;
				for (int i = 0; i < nbytes; i++)
					fill_word = {fill_word[23:0], dsrp_pkg::DSD_SILENCE};
				w.data = fill_word;
				w.silence = 1'b1;
				for (int unsigned i = placed; i < cpb; i++) begin
					w.chan = 1'b0;
					res.push_back(w);
					w.chan = 1'b1;
					res.push_back(w);
				end
			end
			placed = 0;
			stream_done = 1'b1;
		end
		blk_chunks = placed[4:0];
		res[res.size()-1].last = 1'b1;
	endfunction

	function automatic chunk_t rand_chunk(input logic eos);
		chunk_t c;
		c.l0 = 8'($urandom_range(0, 255));
		c.r0 = 8'($urandom_range(0, 255));
		c.l1 = 8'($urandom_range(0, 255));
		c.r1 = 8'($urandom_range(0, 255));
		c.eos = eos;
		return c;
	endfunction

	function automatic row_t chunk_row(input logic [7:0] l0, input logic [7:0] r0,
			input logic [7:0] l1, input logic [7:0] r1, input bit typed = 1'b0,
			input logic [31:0] el = '0, input logic [31:0] er = '0);
		row_t r;
		r.kind = ROW_CHUNK;
		r.c = '{l0: l0, r0: r0, l1: l1, r1: r1, eos: 1'b0};
		r.typed = typed;
		r.exp_l = el;
		r.exp_r = er;
		r.idx = dsrp_pkg::REG_PAD;
		r.val = '0;
		return r;
	endfunction

	function automatic row_t cfg_row(input dsrp_pkg::reg_idx_t idx, input logic [31:0] val);
		row_t r;
		r = chunk_row(8'h0, 8'h0, 8'h0, 8'h0);
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	task automatic send_chunk(input chunk_t c, input bit typed = 1'b0,
			input logic [31:0] el = '0, input logic [31:0] er = '0);
		int    gap;
		word_t words[$];
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			chunk_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chunk_bus.left_first    <= c.l0;
		chunk_bus.right_first   <= c.r0;
		chunk_bus.left_second   <= c.l1;
		chunk_bus.right_second  <= c.r1;
		chunk_bus.end_of_stream <= c.eos;
		chunk_bus.valid         <= 1'b1;
		@(posedge clk);
		while (!chunk_bus.ready)
			@(posedge clk);
		repack_chunk(c, words);
		if (typed && words.size() >= 2) begin
			words[0].data = el;
			words[1].data = er;
		end
		foreach (words[i])
			pending_words.push_back(words[i]);
	endtask

	// block drained and quiet before a register write
	task automatic settle();
		chunk_bus.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input dsrp_pkg::reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		settle();
		mask = (idx == dsrp_pkg::REG_PAD) ? 32'h7 : 32'h3f;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == dsrp_pkg::REG_PAD)
			pad_reg = val[dsrp_pkg::PAD_W-1:0];
		else
			blk_reg = val[dsrp_pkg::BLK_W-1:0];
		// read back right away
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) != (val & mask))
			report("register readback", val & mask, prdata & mask);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// output side: random stalls, every beat checked against the oldest expectation
	initial begin
		int    stall;
		word_t e;
		word_bus.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = sink_idle ? $urandom_range(0, 3) : 0;
			if (stall != 0) begin
				word_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			word_bus.ready <= 1'b1;
			@(posedge clk);
			while (!word_bus.valid)
				@(posedge clk);
			if (pending_words.size() == 0) begin
				report("unexpected beat", '0, word_bus.data_word);
			end else begin
				e = pending_words.pop_front();
				if (word_bus.data_word !== e.data)
					report("data_word", e.data, word_bus.data_word);
				if (word_bus.byte_count !== e.nbytes)
					report("byte_count", 32'(e.nbytes), 32'(word_bus.byte_count));
				if (word_bus.channel !== e.chan)
					report("channel", 32'(e.chan), 32'(word_bus.channel));
				if (word_bus.is_silence !== e.silence)
					report("is_silence", 32'(e.silence), 32'(word_bus.is_silence));
				if (word_bus.last !== e.last)
					report("last", 32'(e.last), 32'(word_bus.last));
			end
		end
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int     sent;
		int     wait_cnt;
		chunk_t c;
		errors = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		chunk_bus.valid = 1'b0;
		chunk_bus.left_first = '0;
		chunk_bus.right_first = '0;
		chunk_bus.left_second = '0;
		chunk_bus.right_second = '0;
		chunk_bus.end_of_stream = 1'b0;
		pad_reg = 3'd0;
		blk_reg = 6'd4;
		blk_chunks = '0;
		stream_done = 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;

		// reset defaults, byte extremes, padding rounding and saturation, block sizing
		plan.push_back(chunk_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_0000,
			32'h0000_0000));
		plan.push_back(chunk_row(8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 32'h0000_ffff,
			32'h0000_ffff));
		plan.push_back(chunk_row(8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 32'h0000_1256,
			32'h0000_3478));
		plan.push_back(chunk_row(8'ha5, 8'h5a, 8'hc3, 8'h3c));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd3));
		plan.push_back(chunk_row(8'h80, 8'h01, 8'h01, 8'h80, 1'b1, 32'h0000_8001,
			32'h0000_0180));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd7));
		plan.push_back(chunk_row(8'hff, 8'h00, 8'h00, 8'hff, 1'b1, 32'h0000_ff00,
			32'h0000_00ff));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd1));
		plan.push_back(chunk_row(8'h5a, 8'ha5, 8'h3c, 8'hc3));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd5));
		plan.push_back(chunk_row(8'h01, 8'h02, 8'h04, 8'h08));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd6));
		plan.push_back(chunk_row(8'h10, 8'h20, 8'h40, 8'h80));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd4));
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd5));
		plan.push_back(chunk_row(8'h7f, 8'hfe, 8'h81, 8'h18));
		plan.push_back(chunk_row(8'h33, 8'hcc, 8'h55, 8'haa));
		plan.push_back(chunk_row(8'he7, 8'h7e, 8'h99, 8'h66));
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd0));
		plan.push_back(chunk_row(8'h0f, 8'hf0, 8'h3c, 8'hc3));
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd1));
		plan.push_back(chunk_row(8'hde, 8'had, 8'hbe, 8'hef));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd2));
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd63));
		plan.push_back(chunk_row(8'h11, 8'h22, 8'h33, 8'h44));
		plan.push_back(chunk_row(8'h55, 8'h66, 8'h77, 8'h88));
		plan.push_back(chunk_row(8'h99, 8'haa, 8'hbb, 8'hcc));
		// shrink the block under a count that already passes it
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd2));
		plan.push_back(chunk_row(8'h69, 8'h96, 8'h00, 8'hff));
		plan.push_back(cfg_row(dsrp_pkg::REG_PAD, 32'd0));
		plan.push_back(cfg_row(dsrp_pkg::REG_BLOCK, 32'd4));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				cfg_write(plan[i].idx, plan[i].val);
			else
				send_chunk(plan[i].c, plan[i].typed, plan[i].exp_l, plan[i].exp_r);
		end

		// random phases, config changed between them without clearing the block count
		for (int p = 0; p < 10; p++) begin
			cfg_write(dsrp_pkg::REG_PAD, $urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: begin
					case ($urandom_range(0, 3))
						0: cfg_write(dsrp_pkg::REG_BLOCK, 32'd0);
						1: cfg_write(dsrp_pkg::REG_BLOCK, 32'd1);
						2: cfg_write(dsrp_pkg::REG_BLOCK, 32'd32);
						default: cfg_write(dsrp_pkg::REG_BLOCK, 32'd63);
					endcase
				end
				default: cfg_write(dsrp_pkg::REG_BLOCK, $urandom_range(1, 16));
			endcase
			src_idle  = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 30; k++)
				send_chunk(rand_chunk(1'b0));
		end

		// end of stream as the first chunk of a 32-chunk block: longest silence fill
		cfg_write(dsrp_pkg::REG_PAD, 32'd0);
		cfg_write(dsrp_pkg::REG_BLOCK, 32'd63);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		sent = 0;
		while (sent < 8 || blk_chunks != 5'd0) begin
			send_chunk(rand_chunk(1'b0));
			sent++;
		end
		send_chunk(rand_chunk(1'b1));

		// items after the end of the stream are dropped
		for (int k = 0; k < 3; k++) begin
			c = rand_chunk(1'($urandom_range(0, 1)));
			send_chunk(c);
		end
		chunk_bus.valid <= 1'b0;

		wait_cnt = 0;
		while (pending_words.size() != 0 && wait_cnt < 5000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (20) @(posedge clk);
		if (pending_words.size() != 0)
			report("words never delivered", '0, 32'(pending_words.size()));

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
